FILE: hw/rtl/mwo_pkg.sv
// ----------------------------------------------------------------------------
// mwo_pkg
// Types, constants and tables shared by the mecanum odometry modules.
// ----------------------------------------------------------------------------
package mwo_pkg;

  localparam int unsigned CordicSteps = 24;
  localparam int unsigned StepW = 5;

  localparam logic signed [13:0] RpmToRad = 14'sd6863;
  localparam logic signed [19:0] TwoPi = 20'sd411775;
  localparam logic signed [19:0] Pi = 20'sd205887;
  localparam logic signed [19:0] HalfPi = 20'sd102944;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  // Two to the 31st modulo the full turn, used to undo the heading offset.
  localparam logic signed [31:0] TwoPiWrap = 32'sd77023;

  localparam logic [1:0] CfgRadius = 2'd0;
  localparam logic [1:0] CfgLever = 2'd1;
  localparam logic [1:0] CfgDead = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUMS,
    ST_MULT,
    ST_DIV,
    ST_RATES,
    ST_REDUCE,
    ST_CORDIC,
    ST_ROT1,
    ST_ROT2,
    ST_INTEG1,
    ST_INTEG2,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load_in;
    logic set_pose;
    logic do_sums;
    logic do_mult;
    logic div_start;
    logic do_rates;
    logic do_reduce;
    logic cordic_step;
    logic do_rot1;
    logic do_rot2;
    logic do_integ1;
    logic do_integ2;
  } cmd_t;

  typedef struct packed {
    logic is_set;
    logic pose_loaded;
    logic div_done;
    logic cordic_last;
  } status_t;

  function automatic logic signed [33:0] atan_lut(input logic [StepW-1:0] i);
    logic signed [33:0] r;
    r = '0;
    case (i)
      5'd0: r = 34'sd843314857;
      5'd1: r = 34'sd497837830;
      5'd2: r = 34'sd263043837;
      5'd3: r = 34'sd133525159;
      5'd4: r = 34'sd67021687;
      5'd5: r = 34'sd33543516;
      5'd6: r = 34'sd16775851;
      5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194283;
      5'd9: r = 34'sd2097149;
      default: r = (i < 5'd24) ? (34'sd1 <<< (5'd30 - i)) : 34'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

FILE: hw/rtl/mwo_if.sv
// ----------------------------------------------------------------------------
// mwo_if
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface mwo_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic signed [12:0] rpm_wheel1;
  logic signed [12:0] rpm_wheel2;
  logic signed [12:0] rpm_wheel3;
  logic signed [12:0] rpm_wheel4;
  logic [15:0] dt_ticks;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic signed [31:0] new_heading;
  modport source(output valid, req_type, rpm_wheel1, rpm_wheel2, rpm_wheel3, rpm_wheel4,
                 dt_ticks, new_x, new_y, new_heading, input ready);
  modport sink(input valid, req_type, rpm_wheel1, rpm_wheel2, rpm_wheel3, rpm_wheel4,
               dt_ticks, new_x, new_y, new_heading, output ready);
endinterface

interface mwo_res_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  logic signed [31:0] vel_fwd;
  logic signed [31:0] vel_side;
  logic signed [31:0] vel_turn;
  logic pose_valid;
  modport source(output valid, pos_x, pos_y, heading, vel_fwd, vel_side, vel_turn,
                 pose_valid, input ready);
  modport sink(input valid, pos_x, pos_y, heading, vel_fwd, vel_side, vel_turn,
               pose_valid, output ready);
endinterface

interface mwo_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: hw/rtl/mecanum_wheel_odometry_core.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_odometry_core
// Mecanum wheel odometry in Q16.16 with deadband and saturating pose.
// ----------------------------------------------------------------------------
// One request is handled at a time. An update beat passes through the serial
// divider for the turn rate, during which the heading is also reduced to one
// turn, and the 24-step CORDIC for sine and cosine before its result shows; a
// set-pose beat or an update before a pose is loaded skips both. A result
// waits in its output register until taken, and no new beat is accepted while
// it waits.
module mecanum_wheel_odometry_core (
  input  logic clk_i,
  input  logic rst_ni,
  mwo_req_if.sink   req,
  mwo_res_if.source res,
  mwo_cfg_if.sink   cfg
);
  import mwo_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic [15:0] radius_q, lever_q, dead_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd4588;
      lever_q <= 16'd25002;
      dead_q <= 16'd3277;
    end else if (cfg.valid) begin
      case (cfg.index)
        CfgRadius: radius_q <= cfg.data;
        CfgLever: lever_q <= cfg.data;
        CfgDead: dead_q <= cfg.data;
        default: ;
      endcase
    end
  end

  mwo_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready),
    .out_valid_o(res.valid), .out_ready_i(res.ready),
    .status_i(status), .cmd_o(cmd)
  );

  mwo_dpath u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .req_type_i(req.req_type), .rpm1_i(req.rpm_wheel1), .rpm2_i(req.rpm_wheel2),
    .rpm3_i(req.rpm_wheel3), .rpm4_i(req.rpm_wheel4), .dt_i(req.dt_ticks),
    .new_x_i(req.new_x), .new_y_i(req.new_y), .new_h_i(req.new_heading),
    .radius_i(radius_q), .lever_i(lever_q), .dead_i(dead_q),
    .pos_x_o(res.pos_x), .pos_y_o(res.pos_y), .heading_o(res.heading),
    .vel_fwd_o(res.vel_fwd), .vel_side_o(res.vel_side), .vel_turn_o(res.vel_turn),
    .pose_valid_o(res.pose_valid)
  );
endmodule

FILE: hw/rtl/mwo_ctrl.sv
// ----------------------------------------------------------------------------
// mwo_ctrl
// Sequencer for one request: a pose set, or kinematics, division, CORDIC, integration.
// ----------------------------------------------------------------------------
module mwo_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mwo_pkg::status_t  status_i,
  output mwo_pkg::cmd_t     cmd_o
);
  import mwo_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        in_ready_o = !out_valid_q;
        if (in_valid_i && !out_valid_q) begin
          cmd_o.load_in = 1'b1;
          state_d = ST_SUMS;
        end
      end
      ST_SUMS: begin
        if (status_i.is_set) begin
          cmd_o.set_pose = 1'b1;
          state_d = ST_OUT;
        end else if (!status_i.pose_loaded) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.do_sums = 1'b1;
          state_d = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd_o.do_mult = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_start = 1'b1;
        if (status_i.div_done) begin
          state_d = ST_RATES;
        end
      end
      ST_RATES: begin
        cmd_o.do_rates = 1'b1;
        state_d = ST_REDUCE;
      end
      ST_REDUCE: begin
        cmd_o.do_reduce = 1'b1;
        state_d = ST_CORDIC;
      end
      ST_CORDIC: begin
        cmd_o.cordic_step = 1'b1;
        if (status_i.cordic_last) begin
          state_d = ST_ROT1;
        end
      end
      ST_ROT1: begin
        cmd_o.do_rot1 = 1'b1;
        state_d = ST_ROT2;
      end
      ST_ROT2: begin
        cmd_o.do_rot2 = 1'b1;
        state_d = ST_INTEG1;
      end
      ST_INTEG1: begin
        cmd_o.do_integ1 = 1'b1;
        state_d = ST_INTEG2;
      end
      ST_INTEG2: begin
        cmd_o.do_integ2 = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_d) begin
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q) else $error("result dropped");
  a_start_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SUMS)) else $error("no start");
`endif
endmodule

FILE: hw/rtl/mwo_dpath.sv
// ----------------------------------------------------------------------------
// mwo_dpath
// Datapath: wheel sums, multipliers, serial divider, CORDIC, pose.
// ----------------------------------------------------------------------------
module mwo_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mwo_pkg::cmd_t      cmd_i,
  output mwo_pkg::status_t   status_o,
  input  logic               req_type_i,
  input  logic signed [12:0] rpm1_i,
  input  logic signed [12:0] rpm2_i,
  input  logic signed [12:0] rpm3_i,
  input  logic signed [12:0] rpm4_i,
  input  logic [15:0]        dt_i,
  input  logic signed [31:0] new_x_i,
  input  logic signed [31:0] new_y_i,
  input  logic signed [31:0] new_h_i,
  input  logic [15:0]        radius_i,
  input  logic [15:0]        lever_i,
  input  logic [15:0]        dead_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] heading_o,
  output logic signed [31:0] vel_fwd_o,
  output logic signed [31:0] vel_side_o,
  output logic signed [31:0] vel_turn_o,
  output logic               pose_valid_o
);
  import mwo_pkg::*;

  localparam int unsigned DivSteps = 48;
  localparam int unsigned ModSteps = 14;

  logic               type_q;
  logic signed [12:0] rpm_q [4];
  logic [15:0]        dt_q;
  logic signed [31:0] nx_q, ny_q, nh_q;
  logic signed [31:0] x_q, y_q, h_q;
  logic               loaded_q;
  logic signed [15:0] s_q, d_q, t_q;
  logic signed [48:0] ps_q, pd_q, pt_q;
  logic [47:0]        quo_q;
  logic [47:0]        num_q;
  logic [18:0]        rem_q;
  logic [5:0]         dcnt_q;
  logic               dbusy_q;
  logic               tneg_q;
  logic [31:0]        hm_q;
  logic signed [31:0] vf_q, vs_q, vt_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic               neg_q;
  logic [StepW-1:0]   ccnt_q;
  logic signed [63:0] m1_q, m2_q, m3_q, m4_q;

  logic signed [15:0] s_sum, d_sum, t_sum;
  logic signed [31:0] vf_n, vs_n, vt_n;
  logic signed [48:0] rnd_f, rnd_s;
  logic signed [49:0] tq;
  logic [18:0]        divisor;
  logic [19:0]        trial;
  logic [3:0]         hm_k;
  logic [31:0]        hm_sub;
  logic signed [31:0] hr;
  logic signed [31:0] r0, r1, r2;
  logic               fold_neg;
  logic signed [33:0] xs, ys;
  logic signed [64:0] fx_w, fy_w;
  logic signed [48:0] dx, dy, dh;

  function automatic logic signed [31:0] dead_f(input logic signed [31:0] v,
                                                input logic [15:0] db);
    logic [32:0] a;
    a = v[31] ? (33'd0 - {v[31], v}) : {1'b0, v};
    return (a < {17'd0, db}) ? 32'sd0 : v;
  endfunction

  always_comb begin
    s_sum = 16'(rpm_q[0]) + 16'(rpm_q[1]) + 16'(rpm_q[2]) + 16'(rpm_q[3]);
    d_sum = 16'(rpm_q[1]) + 16'(rpm_q[2]) - 16'(rpm_q[0]) - 16'(rpm_q[3]);
    t_sum = 16'(rpm_q[1]) + 16'(rpm_q[3]) - 16'(rpm_q[0]) - 16'(rpm_q[2]);
    rnd_f = (ps_q + 49'sd131072) >>> 18;
    rnd_s = (pd_q + 49'sd131072) >>> 18;
    tq = tneg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
    vf_n = dead_f(sat32(64'(rnd_f)), dead_i);
    vs_n = dead_f(sat32(64'(rnd_s)), dead_i);
    vt_n = dead_f(sat32(64'(tq)), dead_i);
    divisor = {1'b0, (lever_i == 16'd0) ? 16'd1 : lever_i, 2'b00};
    trial = {rem_q, num_q[47]} - {1'b0, divisor};
    hm_k = 4'(6'(ModSteps - 1) - dcnt_q);
    hm_sub = 32'($unsigned(TwoPi)) << hm_k;
    hr = $signed(hm_q) - TwoPiWrap;
    r0 = (hr < 0) ? hr + 32'(TwoPi) : hr;
    r1 = (r0 >= 32'(Pi)) ? r0 - 32'(TwoPi) : r0;
    fold_neg = 1'b0;
    r2 = r1;
    if (r1 > 32'(HalfPi)) begin
      r2 = r1 - 32'(Pi);
      fold_neg = 1'b1;
    end else if (r1 < -32'(HalfPi)) begin
      r2 = r1 + 32'(Pi);
      fold_neg = 1'b1;
    end
    xs = cx_q >>> ccnt_q;
    ys = cy_q >>> ccnt_q;
    fx_w = (65'(m1_q) - 65'(m2_q) + 65'sd536870912) >>> 30;
    fy_w = (65'(m3_q) + 65'(m4_q) + 65'sd536870912) >>> 30;
    dx = 49'((m1_q + 64'sd32768) >>> 16);
    dy = 49'((m2_q + 64'sd32768) >>> 16);
    dh = 49'((m3_q + 64'sd32768) >>> 16);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
      h_q <= '0;
      loaded_q <= 1'b0;
      dbusy_q <= 1'b0;
      dcnt_q <= '0;
      ccnt_q <= '0;
    end else begin
      if (cmd_i.set_pose) begin
        x_q <= nx_q;
        y_q <= ny_q;
        h_q <= nh_q;
        loaded_q <= 1'b1;
      end
      if (cmd_i.div_start && !dbusy_q) begin
        dbusy_q <= 1'b1;
        dcnt_q <= '0;
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q + 6'd1;
        if (dcnt_q == 6'(DivSteps - 1)) dbusy_q <= 1'b0;
      end
      if (cmd_i.do_reduce) ccnt_q <= '0;
      else if (cmd_i.cordic_step) ccnt_q <= ccnt_q + 5'd1;
      if (cmd_i.do_integ2) begin
        x_q <= sat32(64'(x_q) + 64'(dx));
        y_q <= sat32(64'(y_q) + 64'(dy));
        h_q <= sat32(64'(h_q) + 64'(dh));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      type_q <= req_type_i;
      rpm_q[0] <= rpm1_i;
      rpm_q[1] <= rpm2_i;
      rpm_q[2] <= rpm3_i;
      rpm_q[3] <= rpm4_i;
      dt_q <= dt_i;
      nx_q <= new_x_i;
      ny_q <= new_y_i;
      nh_q <= new_h_i;
      vf_q <= '0;
      vs_q <= '0;
      vt_q <= '0;
    end
    if (cmd_i.do_sums) begin
      s_q <= s_sum;
      d_q <= d_sum;
      t_q <= t_sum;
    end
    if (cmd_i.do_mult) begin
      ps_q <= 49'(s_q) * RpmToRad * $signed({1'b0, radius_i});
      pd_q <= 49'(d_q) * RpmToRad * $signed({1'b0, radius_i});
      pt_q <= 49'(t_q) * RpmToRad * $signed({1'b0, radius_i});
    end
    if (cmd_i.div_start && !dbusy_q) begin
      tneg_q <= pt_q[48];
      num_q <= pt_q[48] ? 48'(-pt_q) : pt_q[47:0];
      rem_q <= '0;
      quo_q <= '0;
      hm_q <= {~h_q[31], h_q[30:0]};
    end else if (dbusy_q) begin
      num_q <= {num_q[46:0], 1'b0};
      if (!trial[19]) begin
        rem_q <= trial[18:0];
        quo_q <= {quo_q[46:0], 1'b1};
      end else begin
        rem_q <= {rem_q[17:0], num_q[47]};
        quo_q <= {quo_q[46:0], 1'b0};
      end
      if ((dcnt_q < 6'(ModSteps)) && (hm_q >= hm_sub)) begin
        hm_q <= hm_q - hm_sub;
      end
    end
    if (cmd_i.do_rates) begin
      vf_q <= vf_n;
      vs_q <= vs_n;
      vt_q <= vt_n;
    end
    if (cmd_i.do_reduce) begin
      cx_q <= CordicGain;
      cy_q <= '0;
      cz_q <= 34'(r2) <<< 14;
      neg_q <= fold_neg;
    end else if (cmd_i.cordic_step) begin
      if (!cz_q[33]) begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - atan_lut(ccnt_q);
      end else begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + atan_lut(ccnt_q);
      end
    end
    if (cmd_i.do_rot1) begin
      if (neg_q) begin
        cx_q <= -cx_q;
        cy_q <= -cy_q;
      end
    end
    if (cmd_i.do_rot2) begin
      m1_q <= 64'(vf_q) * 64'(cx_q);
      m2_q <= 64'(vs_q) * 64'(cy_q);
      m3_q <= 64'(vf_q) * 64'(cy_q);
      m4_q <= 64'(vs_q) * 64'(cx_q);
    end
    if (cmd_i.do_integ1) begin
      m1_q <= 64'(fx_w) * $signed({1'b0, dt_q});
      m2_q <= 64'(fy_w) * $signed({1'b0, dt_q});
      m3_q <= 64'(vt_q) * $signed({1'b0, dt_q});
    end
  end

  assign status_o.is_set = type_q;
  assign status_o.pose_loaded = loaded_q;
  assign status_o.div_done = dbusy_q && (dcnt_q == 6'(DivSteps - 1));
  assign status_o.cordic_last = (ccnt_q == 5'(CordicSteps - 1));

  assign pos_x_o = x_q;
  assign pos_y_o = y_q;
  assign heading_o = h_q;
  assign vel_fwd_o = vf_q;
  assign vel_side_o = vs_q;
  assign vel_turn_o = vt_q;
  assign pose_valid_o = loaded_q;

`ifndef SYNTHESIS
  a_loaded_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q |=> loaded_q) else $error("pose flag lost");
  a_set_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.set_pose |=> (x_q == $past(nx_q))) else $error("pose not loaded");
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dbusy_q |-> (dcnt_q == 6'd0) || (dcnt_q == 6'(DivSteps))) else $error("div count");
`endif
endmodule
